// File: src/szd_pkg.sv
// shared types, widths and constants for the sliding window z-score detector
// no dependencies
package szd_pkg;

  localparam int VAL_W   = 32;
  localparam int TIME_W  = 48;
  localparam int WIN_W   = 32;
  localparam int THR_W   = 15;
  localparam int Z_W     = 16;
  localparam int MID_W   = 4;
  localparam int MID_N   = 16;
  localparam int N_W     = 13;
  localparam int SUM_W   = 44;
  localparam int SSQ_W   = 76;
  localparam int D_W     = 88;
  localparam int ROOT_W  = 44;
  localparam int DIV_W   = 44;
  localparam int HALF_W  = 22;
  localparam int PROD_W  = SUM_W + HALF_W;
  localparam int ENTRY_W = VAL_W + TIME_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_THRESHOLD = 2'd1;

  localparam logic [WIN_W-1:0] WINDOW_MS_RST   = 32'd300000;
  localparam logic [THR_W-1:0] Z_THRESHOLD_RST = 15'd768;

  localparam logic [Z_W-1:0] Z_MAX = 16'h7fff;
  localparam logic [Z_W-1:0] Z_MIN = 16'h8000;

endpackage

// File: src/szd_if.sv
// handshake channels for sample beats, result beats and register writes
// depends on szd_pkg
interface szd_in_if;
  import szd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MID_W-1:0]         metric_id;
  logic signed [VAL_W-1:0]  sample_value;
  logic [TIME_W-1:0]        time_ms;
  modport source (output valid, metric_id, sample_value, time_ms, input ready);
  modport sink (input valid, metric_id, sample_value, time_ms, output ready);
endinterface

interface szd_out_if #(parameter int CNT_W = 9);
  import szd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     anomaly;
  logic signed [Z_W-1:0]    z_score;
  logic signed [VAL_W-1:0]  window_mean;
  logic [VAL_W-1:0]         window_stddev;
  logic [CNT_W-1:0]         window_count;
  logic                     window_overflow;
  modport source (output valid, anomaly, z_score, window_mean, window_stddev,
                  window_count, window_overflow, input ready);
  modport sink (input valid, anomaly, z_score, window_mean, window_stddev,
                window_count, window_overflow, output ready);
endinterface

interface szd_cfg_if;
  import szd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [WIN_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/szd_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on szd_pkg
module szd_div import szd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quo_o,
  output logic [DIV_W-1:0] rem_o
);
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] num_q, den_q;
  logic [DIV_W:0]   rem_q, rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[DIV_W-1:0], num_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[DIV_W-2:0], ge};
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = num_q;
  assign rem_o  = rem_q[DIV_W-1:0];
endmodule

// File: src/szd_sqrt.sv
// bitwise integer square root, one result bit per cycle
// depends on szd_pkg
module szd_sqrt import szd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [D_W-1:0]    rad_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);
  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [CNT_W-1:0]  cnt_q;
  logic [D_W-1:0]    rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W:0]    rem_sh, trial;
  logic              ge;

  assign rem_sh = {rem_q[REM_W-2:0], rad_q[D_W-1:D_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(ROOT_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[D_W-3:0], 2'b00};
      rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign root_o = root_q;
endmodule

// File: src/sliding_window_zscore_detector.sv
// Sliding window z-score detector. One sample beat is taken at a time; it is
// appended to its metric's ring in a single sample memory, stale entries are
// pruned from the front, each by a read state and a check state, then the window
// is summed at one entry per cycle through the memory read port, followed by a
// square root (run alongside the mean division) and two further divisions.
// The result waits in an output register, so no result is ever dropped.
// top level, depends on szd_pkg, szd_if, szd_div and szd_sqrt
module sliding_window_zscore_detector import szd_pkg::*; #(
  parameter int METRICS = 16,
  parameter int DEPTH   = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  szd_in_if.sink    in_i,
  szd_out_if.source out_o,
  szd_cfg_if.sink   cfg_i
);
  localparam int MW = (METRICS > 1) ? $clog2(METRICS) : 1;
  localparam int DW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(METRICS * DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRITE = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PCHK  = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_D     = 4'd7;
  localparam logic [3:0] S_ROOT  = 4'd8;
  localparam logic [3:0] S_SDIV  = 4'd9;
  localparam logic [3:0] S_ZDIV  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_q, state_d;

  logic [WIN_W-1:0] win_q;
  logic [THR_W-1:0] thr_q;

  logic [DW-1:0] oldest_q [METRICS];
  logic [CW-1:0] held_q [METRICS];
  logic          st_we;

  logic [MW-1:0]           m_q, m_d, midx;
  logic signed [VAL_W-1:0] v_q, v_d;
  logic [TIME_W-1:0]       t_q, t_d;
  logic [DW-1:0]           old_q, old_d, rptr_q, rptr_d;
  logic [CW-1:0]           cnt_q, cnt_d, iss_q, iss_d;
  logic                    ovf_q, ovf_d;
  logic                    rdv_q, rdv_d, sqv_q;
  logic signed [VAL_W-1:0] x_q;
  logic [2*VAL_W-1:0]      sq_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SSQ_W-1:0]        ssq_q, ssq_d;
  logic [D_W-1:0]          nsq_q, nsq_d;
  logic [PROD_W-1:0]       p1_q, p1_d, p2_q, p2_d;
  logic signed [VAL_W-1:0] mean_q, mean_d;
  logic [DIV_W-1:0]        sd_q, sd_d;
  logic                    an_q, an_d;
  logic [Z_W-1:0]          z_q, z_d;

  logic                    ov_q, ov_d, out_ld;
  logic                    oan_q;
  logic [Z_W-1:0]          oz_q;
  logic [VAL_W-1:0]        omean_q, osd_q;
  logic [CW-1:0]           ocnt_q;
  logic                    oovf_q;

  logic [ENTRY_W-1:0] store_mem [METRICS*DEPTH];
  logic [ENTRY_W-1:0] rdata_q, wdata;
  logic               mem_we, mem_re;
  logic [DW-1:0]      wslot, rslot;
  logic [AW-1:0]      base, waddr, raddr;
  logic [DW:0]        slot_sum;

  logic               div_start, div_busy, sq_start, sq_busy;
  logic [DIV_W-1:0]   div_num, div_den, div_quo, div_rem;
  logic [ROOT_W-1:0]  root;
  logic [D_W-1:0]     rad;

  logic [SUM_W-1:0]   absum, mean_w;
  logic [N_W-1:0]     n_ext;
  logic [VAL_W-1:0]   ax;
  logic [VAL_W-1:0]   rd_val;
  logic [TIME_W-1:0]  rd_time;
  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]     dmag;

  always_comb begin
    midx = '0;
    for (int i = 0; i < MID_N; i++) begin
      if (in_i.metric_id == MID_W'(i)) begin
        midx = MW'(i % METRICS);
      end
    end
  end

  assign rd_val  = rdata_q[ENTRY_W-1:TIME_W];
  assign rd_time = rdata_q[TIME_W-1:0];
  assign ax      = rd_val[VAL_W-1] ? ~rd_val + 1'b1 : rd_val;
  assign absum   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign n_ext   = N_W'(cnt_q);

  assign base     = AW'(m_q) * AW'(DEPTH);
  assign slot_sum = {1'b0, old_q} + (DW+1)'(cnt_q);
  assign wslot    = (slot_sum >= (DW+1)'(DEPTH)) ? DW'(slot_sum - (DW+1)'(DEPTH))
                                                 : DW'(slot_sum);
  assign waddr    = base + AW'(wslot);
  assign raddr    = base + AW'(rslot);
  assign wdata    = {v_q, t_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= store_mem[raddr];
    end
  end

  szd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  szd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (rad),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  assign rad = nsq_q - D_W'(p1_q) - (D_W'(p2_q) << HALF_W);

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_MS_RST;
      thr_q <= Z_THRESHOLD_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_WINDOW_MS) begin
        win_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_Z_THRESHOLD) begin
        thr_q <= cfg_i.data[THR_W-1:0];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    m_d       = m_q;
    v_d       = v_q;
    t_d       = t_q;
    old_d     = old_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    rptr_d    = rptr_q;
    iss_d     = iss_q;
    rdv_d     = 1'b0;
    sum_d     = sum_q;
    ssq_d     = ssq_q;
    nsq_d     = nsq_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    mean_d    = mean_q;
    sd_d      = sd_q;
    an_d      = an_q;
    z_d       = z_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rslot     = old_q;
    st_we     = 1'b0;
    div_start = 1'b0;
    div_num   = absum;
    div_den   = DIV_W'(n_ext);
    sq_start  = 1'b0;
    out_ld    = 1'b0;
    mean_w    = '0;
    diff      = '0;
    dmag      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          m_d   = midx;
          v_d   = in_i.sample_value;
          t_d   = in_i.time_ms;
          old_d = oldest_q[midx];
          cnt_d = held_q[midx];
          ovf_d = 1'b0;
          if (held_q[midx] == CW'(DEPTH)) begin
            old_d = (oldest_q[midx] == DW'(DEPTH - 1)) ? '0 : oldest_q[midx] + 1'b1;
            cnt_d = CW'(DEPTH - 1);
            ovf_d = 1'b1;
          end
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we  = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_PRD;
      end
      S_PRD: begin
        mem_re  = 1'b1;
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (cnt_q != '0 &&
            ({1'b0, rd_time} + (TIME_W+1)'(win_q)) < {1'b0, t_q}) begin
          old_d   = (old_q == DW'(DEPTH - 1)) ? '0 : old_q + 1'b1;
          cnt_d   = cnt_q - 1'b1;
          state_d = S_PRD;
        end else begin
          st_we   = 1'b1;
          rptr_d  = old_q;
          iss_d   = '0;
          sum_d   = '0;
          ssq_d   = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (iss_q != cnt_q) begin
          mem_re = 1'b1;
          rslot  = rptr_q;
          rptr_d = (rptr_q == DW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
          iss_d  = iss_q + 1'b1;
          rdv_d  = 1'b1;
        end
        if (sqv_q) begin
          sum_d = sum_q + {{(SUM_W-VAL_W){x_q[VAL_W-1]}}, x_q};
          ssq_d = ssq_q + SSQ_W'(sq_q);
        end
        if (iss_q == cnt_q && !rdv_q && !sqv_q) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        nsq_d   = D_W'(n_ext) * D_W'(ssq_q);
        p1_d    = PROD_W'(absum) * PROD_W'(absum[HALF_W-1:0]);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        p2_d    = PROD_W'(absum) * PROD_W'(absum[SUM_W-1:HALF_W]);
        state_d = S_D;
      end
      S_D: begin
        sq_start  = 1'b1;
        div_start = 1'b1;
        state_d   = S_ROOT;
      end
      S_ROOT: begin
        if (!div_busy && !sq_busy) begin
          mean_w    = sum_q[SUM_W-1] ? SUM_W'(0 - div_quo - SUM_W'(div_rem != '0))
                                     : div_quo;
          mean_d    = VAL_W'(mean_w);
          div_num   = root;
          div_start = 1'b1;
          state_d   = S_SDIV;
        end
      end
      S_SDIV: begin
        if (!div_busy) begin
          sd_d = div_quo;
          an_d = 1'b0;
          z_d  = '0;
          if (div_quo == '0) begin
            state_d = S_OUT;
          end else begin
            diff      = {v_q[VAL_W-1], v_q} - {mean_q[VAL_W-1], mean_q};
            dmag      = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
            div_num   = DIV_W'({dmag, 8'h00});
            div_den   = div_quo;
            div_start = 1'b1;
            an_d      = diff[VAL_W];
            state_d   = S_ZDIV;
          end
        end
      end
      S_ZDIV: begin
        if (!div_busy) begin
          if (an_q) begin
            z_d = (div_quo > DIV_W'(Z_MIN)) ? Z_MIN : Z_W'(0 - div_quo[Z_W-1:0]);
          end else begin
            z_d = (div_quo > DIV_W'(Z_MAX)) ? Z_MAX : div_quo[Z_W-1:0];
          end
          an_d    = div_quo >= DIV_W'(thr_q);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          out_ld  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ov_d = out_ld | (ov_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdv_q   <= 1'b0;
      sqv_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= rdv_d;
      sqv_q   <= rdv_q;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < METRICS; i++) begin
        oldest_q[i] <= '0;
        held_q[i]   <= '0;
      end
    end else if (st_we) begin
      oldest_q[m_q] <= old_q;
      held_q[m_q]   <= cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    v_q    <= v_d;
    t_q    <= t_d;
    old_q  <= old_d;
    cnt_q  <= cnt_d;
    ovf_q  <= ovf_d;
    rptr_q <= rptr_d;
    iss_q  <= iss_d;
    x_q    <= rd_val;
    sq_q   <= ax * ax;
    sum_q  <= sum_d;
    ssq_q  <= ssq_d;
    nsq_q  <= nsq_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    mean_q <= mean_d;
    sd_q   <= sd_d;
    an_q   <= an_d;
    z_q    <= z_d;
    if (out_ld) begin
      oan_q   <= an_q;
      oz_q    <= z_q;
      omean_q <= mean_q;
      osd_q   <= sd_q[VAL_W-1:0];
      ocnt_q  <= cnt_q;
      oovf_q  <= ovf_q;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.anomaly         = oan_q;
  assign out_o.z_score         = oz_q;
  assign out_o.window_mean     = omean_q;
  assign out_o.window_stddev   = osd_q;
  assign out_o.window_count    = ocnt_q;
  assign out_o.window_overflow = oovf_q;
endmodule
